// ===== hdl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants of the active alarm table
// Sequencer states, outcome codes, word class codes, the table entry layout
// and parameter defaults.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int AAT_ACTIVE_ENTRIES = 16;
  localparam int AAT_TYPE_COUNT     = 16;

  localparam logic [1:0] WC_OTHER    = 2'd0;
  localparam logic [1:0] WC_ACTIVATE = 2'd1;
  localparam logic [1:0] WC_CLEAR    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } aat_state_t;

  typedef enum logic [2:0] {
    RES_IGNORED   = 3'd0,
    RES_EXEMPT    = 3'd1,
    RES_REFRESHED = 3'd2,
    RES_INSERTED  = 3'd3,
    RES_DROPPED   = 3'd4,
    RES_CLEARED   = 3'd5,
    RES_MISSED    = 3'd6
  } aat_outcome_t;

  typedef struct packed {
    logic [3:0]  etype;
    logic [7:0]  node;
    logic [31:0] since;
  } aat_entry_t;

  localparam int AAT_ENTRY_W = $bits(aat_entry_t);

endpackage

// ===== hdl/aat_ram.sv =====
// ----------------------------------------------------------------------------
// aat_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/active_alarm_table_top.sv =====
// ----------------------------------------------------------------------------
// active_alarm_table_top: table of active alarms keyed by type and node
// Scans the entry RAM one slot per cycle to find the key and the lowest free
// slot, then refreshes, inserts, clears, drops or misses, and reports one
// result word. Exempt and other words skip the scan and go straight to the
// finish step, which holds while a result waits at the output. A scan ends
// early on a key match. One word is taken at a time (in_ready only in idle),
// but a new word is accepted while the previous result still waits.
// Reset (rst_n low, synchronous) clears used bits, active count, event total,
// exempt mask and output valid at once; the entry RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module active_alarm_table_top #(
  parameter int ACTIVE_ENTRIES = aat_pkg::AAT_ACTIVE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_event_type,
  input  logic [7:0]  in_node_id,
  input  logic [1:0]  in_word_class,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_active_since,
  output logic [4:0]  out_active_count,
  output logic [31:0] out_event_total,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import aat_pkg::*;

  localparam int IDX_W  = (ACTIVE_ENTRIES > 1) ? $clog2(ACTIVE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ACTIVE_ENTRIES + 1);
  localparam int SLOT_W = (IDX_W > 4) ? IDX_W : 4;
  localparam int SAT_W  = CNT_W + 5;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ACTIVE_ENTRIES - 1);
  localparam logic [4:0]       TYPE_LIM  = 5'(AAT_TYPE_COUNT);
  localparam logic [SAT_W-1:0] COUNT_MAX = SAT_W'(31);

  aat_state_t state_r, state_nxt;

  logic [15:0]               mask_r, mask_nxt;
  logic [31:0]               total_r, total_nxt;
  logic [ACTIVE_ENTRIES-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;

  logic [3:0]  type_r, type_nxt;
  logic [7:0]  node_r, node_nxt;
  logic [1:0]  wc_r, wc_nxt;
  logic [31:0] now_r, now_nxt;
  logic        range_r, range_nxt;
  logic        exempt_r, exempt_nxt;

  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [31:0]      since_r, since_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_outcome_r, out_outcome_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_since_r, out_since_nxt;
  logic [4:0]  out_count_r, out_count_nxt;
  logic [31:0] out_total_r, out_total_nxt;

  logic                   ram_we;
  logic [AAT_ENTRY_W-1:0] ram_wdata;
  logic [AAT_ENTRY_W-1:0] ram_rdata;
  aat_entry_t             rd_entry;
  aat_entry_t             wr_entry;

  assign rd_entry = aat_entry_t'(ram_rdata);
  assign wr_entry = '{etype: type_r, node: node_r, since: now_r};
  assign ram_wdata = AAT_ENTRY_W'(wr_entry);

  aat_ram #(
    .WIDTH (AAT_ENTRY_W),
    .DEPTH (ACTIVE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (free_idx_r),
    .wr_data (ram_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      total_r     <= '0;
      used_r      <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r        <= type_nxt;
    node_r        <= node_nxt;
    wc_r          <= wc_nxt;
    now_r         <= now_nxt;
    range_r       <= range_nxt;
    exempt_r      <= exempt_nxt;
    scan_idx_r    <= scan_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    since_r       <= since_nxt;
    free_idx_r    <= free_idx_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_since_r   <= out_since_nxt;
    out_count_r   <= out_count_nxt;
    out_total_r   <= out_total_nxt;
  end

  always_comb begin
    aat_outcome_t     res;
    logic [IDX_W-1:0] slot;
    logic [31:0]      since_o;
    logic [SLOT_W-1:0] slot_ext;
    logic [SAT_W-1:0]  cnt_ext;

    state_nxt       = state_r;
    mask_nxt        = cfg_wr_en ? cfg_wr_data : mask_r;
    total_nxt       = total_r;
    used_nxt        = used_r;
    count_nxt       = count_r;
    type_nxt        = type_r;
    node_nxt        = node_r;
    wc_nxt          = wc_r;
    now_nxt         = now_r;
    range_nxt       = range_r;
    exempt_nxt      = exempt_r;
    scan_idx_nxt    = scan_idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_valid_nxt   = cmp_valid_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    since_nxt       = since_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_outcome_nxt = out_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_since_nxt   = out_since_r;
    out_count_nxt   = out_count_r;
    out_total_nxt   = out_total_r;
    ram_we          = 1'b0;
    res             = RES_IGNORED;
    slot            = '0;
    since_o         = '0;
    slot_ext        = '0;
    cnt_ext         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          type_nxt      = in_event_type;
          node_nxt      = in_node_id;
          wc_nxt        = in_word_class;
          now_nxt       = in_now_seconds;
          range_nxt     = ({1'b0, in_event_type} < TYPE_LIM);
          exempt_nxt    = mask_r[in_event_type];
          scan_idx_nxt  = '0;
          cmp_valid_nxt = 1'b0;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
          if (range_nxt) begin
            total_nxt = total_r + 32'd1;
          end
          if (range_nxt && !exempt_nxt &&
              (in_word_class == WC_ACTIVATE || in_word_class == WC_CLEAR)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        // issue the next read while checking the entry read last cycle
        cmp_idx_nxt   = scan_idx_r;
        cmp_valid_nxt = 1'b1;
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (cmp_valid_r) begin
          if (used_r[cmp_idx_r] && rd_entry.etype == type_r && rd_entry.node == node_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            since_nxt   = rd_entry.since;
            state_nxt   = ST_FINISH;
          end else begin
            if (!used_r[cmp_idx_r] && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          if (!range_r) begin
            res = RES_IGNORED;
          end else if (exempt_r) begin
            res = RES_EXEMPT;
          end else if (wc_r == WC_ACTIVATE) begin
            if (hit_r) begin
              res     = RES_REFRESHED;
              slot    = hit_idx_r;
              since_o = since_r;
            end else if (free_r) begin
              res       = RES_INSERTED;
              slot      = free_idx_r;
              since_o   = now_r;
              ram_we    = 1'b1;
              used_nxt[free_idx_r] = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              res = RES_DROPPED;
            end
          end else if (wc_r == WC_CLEAR) begin
            if (hit_r) begin
              res       = RES_CLEARED;
              slot      = hit_idx_r;
              since_o   = since_r;
              used_nxt[hit_idx_r] = 1'b0;
              count_nxt = count_r - 1'b1;
            end else begin
              res = RES_MISSED;
            end
          end else begin
            res = RES_IGNORED;
          end
          slot_ext        = SLOT_W'(slot);
          cnt_ext         = SAT_W'(count_nxt);
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = res;
          out_slot_nxt    = slot_ext[3:0];
          out_since_nxt   = since_o;
          out_count_nxt   = (cnt_ext > COUNT_MAX) ? 5'd31 : cnt_ext[4:0];
          out_total_nxt   = total_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_slot_index   = out_slot_r;
  assign out_active_since = out_since_r;
  assign out_active_count = out_count_r;
  assign out_event_total  = out_total_r;

  a_count_matches_used: assert property (
    @(posedge clk) disable iff (!rst_n)
    32'(count_r) == 32'($countones(used_r))
  ) else $error("active count differs from number of used entries");

  a_scan_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(scan_idx_r) < ACTIVE_ENTRIES)
  ) else $error("scan index beyond table");

  a_total_advances: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ({1'b0, in_event_type} < TYPE_LIM))
      |=> (total_r == $past(total_r) + 32'd1)
  ) else $error("event total did not advance on a counted word");

  a_table_only_in_finish: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r != ST_FINISH) |=> (used_r == $past(used_r))
  ) else $error("used bits changed outside the finish step");

endmodule

// ===== dv/aat_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aat_result_checker: result checker for the active alarm table
// Watches the notification, result and mask ports, keeps its own copy of the
// alarm table, predicts one result word per accepted notification and
// compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module aat_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_event_type,
  input  logic [7:0]  in_node_id,
  input  logic [1:0]  in_word_class,
  input  logic [31:0] in_now_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_outcome,
  input  logic [3:0]  out_slot_index,
  input  logic [31:0] out_active_since,
  input  logic [4:0]  out_active_count,
  input  logic [31:0] out_event_total,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatch_count,
  output int          pending_words
);
  import aat_pkg::*;

  typedef struct packed {
    aat_outcome_t outcome;
    logic [3:0]   slot;
    logic [31:0]  since;
    logic [4:0]   count;
    logic [31:0]  total;
  } alarm_result_t;

  logic        slot_used  [AAT_ACTIVE_ENTRIES];
  logic [3:0]  slot_type  [AAT_ACTIVE_ENTRIES];
  logic [7:0]  slot_node  [AAT_ACTIVE_ENTRIES];
  logic [31:0] slot_since [AAT_ACTIVE_ENTRIES];
  logic [31:0] slot_last  [AAT_ACTIVE_ENTRIES];
  logic [31:0] event_total;
  logic [15:0] exempt_mask;

  alarm_result_t alarm_results_due[$];
  alarm_result_t want;

  function automatic alarm_result_t apply_alarm_word(input logic [3:0] etype,
                                                     input logic [7:0] node,
                                                     input logic [1:0] wclass,
                                                     input logic [31:0] now);
    alarm_result_t r;
    int hit;
    int open_slot;
    int used;
    r.outcome = RES_IGNORED;
    r.slot    = '0;
    r.since   = '0;
    hit       = -1;
    open_slot = -1;
    used      = 0;
    if (int'(etype) < AAT_TYPE_COUNT) begin
      event_total = event_total + 32'd1;
      if (exempt_mask[etype]) begin
        r.outcome = RES_EXEMPT;
      end else if (wclass == WC_ACTIVATE || wclass == WC_CLEAR) begin
        // lowest matching slot wins, lowest free slot takes a new key
        for (int i = 0; i < AAT_ACTIVE_ENTRIES; i++) begin
          if (hit < 0 && slot_used[i] && slot_type[i] == etype && slot_node[i] == node)
            hit = i;
          if (open_slot < 0 && !slot_used[i])
            open_slot = i;
        end
        if (wclass == WC_ACTIVATE) begin
          if (hit >= 0) begin
            slot_last[hit] = event_total;
            r.outcome = RES_REFRESHED;
            r.slot    = hit[3:0];
            r.since   = slot_since[hit];
          end else if (open_slot >= 0) begin
            slot_used[open_slot]  = 1'b1;
            slot_type[open_slot]  = etype;
            slot_node[open_slot]  = node;
            slot_since[open_slot] = now;
            slot_last[open_slot]  = event_total;
            r.outcome = RES_INSERTED;
            r.slot    = open_slot[3:0];
            r.since   = now;
          end else begin
            r.outcome = RES_DROPPED;
          end
        end else if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          r.outcome = RES_CLEARED;
          r.slot    = hit[3:0];
          r.since   = slot_since[hit];
        end else begin
          r.outcome = RES_MISSED;
        end
      end
    end
    for (int i = 0; i < AAT_ACTIVE_ENTRIES; i++)
      if (slot_used[i])
        used++;
    r.count = (used > 31) ? 5'd31 : used[4:0];
    r.total = event_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 10)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AAT_ACTIVE_ENTRIES; i++) begin
        slot_used[i]  = 1'b0;
        slot_type[i]  = '0;
        slot_node[i]  = '0;
        slot_since[i] = '0;
        slot_last[i]  = '0;
      end
      event_total = '0;
      exempt_mask = '0;
      alarm_results_due.delete();
    end else begin
      if (cfg_wr_en)
        exempt_mask = cfg_wr_data;
      if (in_valid && in_ready)
        alarm_results_due.push_back(apply_alarm_word(in_event_type, in_node_id,
                                                     in_word_class, in_now_seconds));
      if (out_valid && out_ready) begin
        if (alarm_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word outcome %0d slot %0d",
                                    out_outcome, out_slot_index));
        end else begin
          want = alarm_results_due.pop_front();
          if (out_outcome !== want.outcome || out_slot_index !== want.slot ||
              out_active_since !== want.since || out_active_count !== want.count ||
              out_event_total !== want.total)
            report_mismatch($sformatf(
              "exp outcome %0d slot %0d since %h count %0d total %0d, got %0d %0d %h %0d %0d",
              want.outcome, want.slot, want.since, want.count, want.total,
              out_outcome, out_slot_index, out_active_since, out_active_count,
              out_event_total));
        end
      end
    end
    pending_words <= alarm_results_due.size();
  end

endmodule

// ===== dv/tb_active_alarm_table_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_active_alarm_table_top: testbench of the active alarm table
// Drives a directed opening (insert, refresh, clear, miss, fill to full, drop,
// exempt) and then random phases under several exempt masks, with bursty
// notifications and a stalling result receiver. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_active_alarm_table_top;
  import aat_pkg::*;

  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 265;
  localparam logic [1:0] WC_UNUSED   = 2'd3;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [3:0]  in_event_type  = '0;
  logic [7:0]  in_node_id     = '0;
  logic [1:0]  in_word_class  = '0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_outcome;
  logic [3:0]  out_slot_index;
  logic [31:0] out_active_since;
  logic [4:0]  out_active_count;
  logic [31:0] out_event_total;
  logic        cfg_wr_en      = 1'b0;
  logic [15:0] cfg_wr_data    = '0;

  int mismatch_count;
  int pending_words;
  int burst_left = 0;
  int ready_mode = 0;
  int ready_tick = 0;

  // keys activated lately, so clears mostly hit live alarms
  logic [11:0] recent_keys [16] = '{default: '0};
  int          recent_head = 0;

  always #4 clk = ~clk;

  active_alarm_table_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_event_type    (in_event_type),
    .in_node_id       (in_node_id),
    .in_word_class    (in_word_class),
    .in_now_seconds   (in_now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_slot_index   (out_slot_index),
    .out_active_since (out_active_since),
    .out_active_count (out_active_count),
    .out_event_total  (out_event_total),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  aat_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_event_type    (in_event_type),
    .in_node_id       (in_node_id),
    .in_word_class    (in_word_class),
    .in_now_seconds   (in_now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_slot_index   (out_slot_index),
    .out_active_since (out_active_since),
    .out_active_count (out_active_count),
    .out_event_total  (out_event_total),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .pending_words    (pending_words)
  );

  // receiver: switch between free flow, random stalls, heavy stalls and long holds
  always @(posedge clk) begin
    if (ready_tick == 0) begin
      ready_tick = $urandom_range(16, 96);
      ready_mode = $urandom_range(0, 3);
    end
    ready_tick = ready_tick - 1;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((ready_tick % 16) < 3);
    endcase
  end

  task automatic send_word(input logic [3:0] etype, input logic [7:0] node,
                           input logic [1:0] wclass, input logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid       <= 1'b1;
    in_event_type  <= etype;
    in_node_id     <= node;
    in_word_class  <= wclass;
    in_now_seconds <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every result word is back, then let the block settle
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_mask(input logic [15:0] mask);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_mask;
    logic [3:0]  etype;
    logic [7:0]  node;
    logic [1:0]  wclass;
    int          phase_len;
    int          node_span;
    int          activate_pct;
    int          roll;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_mask(16'h0000);

    send_word(4'd0, 8'h00, WC_ACTIVATE, 32'h0000_0000);
    send_word(4'd15, 8'hFF, WC_ACTIVATE, 32'hFFFF_FFFF);
    send_word(4'd0, 8'h00, WC_ACTIVATE, 32'd123);
    send_word(4'd3, 8'd7, WC_OTHER, $urandom);
    send_word(4'd5, 8'd9, WC_UNUSED, $urandom);
    send_word(4'd15, 8'hFF, WC_CLEAR, $urandom);
    send_word(4'd15, 8'hFF, WC_CLEAR, $urandom);
    // fill the free slots, the last new key finds the table full
    for (int k = 1; k <= 16; k++)
      send_word(k[3:0], 8'(k * 16 + 1), WC_ACTIVATE, $urandom);
    write_mask(16'h8001);
    send_word(4'd15, 8'd3, WC_ACTIVATE, $urandom);
    send_word(4'd0, 8'h00, WC_CLEAR, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        phase_mask = 16'hFFFF;
      else if (p == 1 || p == PHASES - 1)
        phase_mask = 16'h0000;
      else
        phase_mask = 16'($urandom & $urandom);
      write_mask(phase_mask);
      phase_len    = (phase_mask == 16'hFFFF) ? 40 : PHASE_WORDS;
      node_span    = $urandom_range(1, 12);
      activate_pct = $urandom_range(40, 75);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          etype  = 4'($urandom);
          node   = 8'($urandom);
          wclass = 2'($urandom);
        end else begin
          etype = 4'($urandom_range(0, 15));
          node  = 8'($urandom_range(0, node_span));
          roll  = $urandom_range(0, 99);
          if (roll < activate_pct) begin
            wclass = WC_ACTIVATE;
            recent_keys[recent_head] = {etype, node};
            recent_head = (recent_head + 1) % 16;
          end else if (roll < 95) begin
            wclass = WC_CLEAR;
            if ($urandom_range(0, 3) != 0)
              {etype, node} = recent_keys[4'($urandom_range(0, 15))];
          end else begin
            wclass = WC_OTHER;
          end
        end
        if (i == phase_len / 2)
          drain_results();
        send_word(etype, node, wclass, $urandom);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
